// ===== design/wss_pkg.sv =====
// Package for the weekly setpoint schedule unit: field widths, calendar constants,
// sequencer step and condition codes, the control word type, the microcode ROM and day_bits.
// Depends on nothing; used by the top level.
package wss_pkg;

  localparam int MaxEntriesDef = 16;
  localparam int MinPerHour    = 60;
  localparam int MinPerDay     = 24 * 60;
  localparam int DaysPerWeek   = 7;

  localparam int SlotW    = 4;
  localparam int DaysW    = 7;
  localparam int MinuteW  = 11;
  localparam int TempW    = 12;
  localparam int WdayW    = 3;
  localparam int HourW    = 5;
  localparam int MinW     = 6;
  localparam int IndexW   = 5;
  localparam int EntryW   = DaysW + MinuteW + TempW;
  localparam int CfgCntW  = 5;
  localparam int CfgDataW = 5;
  localparam int CfgAddrW = 1;
  localparam int SDataW   = 56;
  localparam int MDataW   = 24;

  localparam logic [CfgAddrW-1:0] CfgEnabled = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgCount   = 1'd1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam int StepW = 3;
  localparam logic [StepW-1:0] S_IDLE  = 3'd0;
  localparam logic [StepW-1:0] S_CHECK = 3'd1;
  localparam logic [StepW-1:0] S_SCAN  = 3'd2;
  localparam logic [StepW-1:0] S_DRAIN = 3'd3;
  localparam logic [StepW-1:0] S_FETCH = 3'd4;
  localparam logic [StepW-1:0] S_FINAL = 3'd5;

  localparam int CondW = 3;
  localparam logic [CondW-1:0] C_NEVER    = 3'd0;
  localparam logic [CondW-1:0] C_ALWAYS   = 3'd1;
  localparam logic [CondW-1:0] C_QUERY    = 3'd2;
  localparam logic [CondW-1:0] C_SKIP     = 3'd3;
  localparam logic [CondW-1:0] C_LAST     = 3'd4;
  localparam logic [CondW-1:0] C_OUT_FREE = 3'd5;

  typedef struct packed {
    logic             init;
    logic             rd_scan;
    logic             rd_best;
    logic             emit;
    logic             hold;
    logic [CondW-1:0] cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  // On a true condition the sequencer jumps to target; otherwise it holds or steps on.
  function automatic ctrl_t ucode_rom(input logic [StepW-1:0] pc);
    ctrl_t cw;
    cw = '0;
    unique case (pc)
      S_IDLE: begin
        cw.hold = 1'b1; cw.cond = C_QUERY; cw.target = S_CHECK;
      end
      S_CHECK: begin
        cw.init = 1'b1; cw.cond = C_SKIP; cw.target = S_FINAL;
      end
      S_SCAN: begin
        cw.rd_scan = 1'b1; cw.hold = 1'b1; cw.cond = C_LAST; cw.target = S_DRAIN;
      end
      S_DRAIN: begin
        cw.cond = C_NEVER; cw.target = S_IDLE;
      end
      S_FETCH: begin
        cw.rd_best = 1'b1; cw.cond = C_NEVER; cw.target = S_IDLE;
      end
      S_FINAL: begin
        cw.emit = 1'b1; cw.hold = 1'b1; cw.cond = C_OUT_FREE; cw.target = S_IDLE;
      end
      default: begin
        cw.cond = C_ALWAYS; cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

  // Bit b of the result is the mask bit of the day that lies b days before today.
  function automatic logic [DaysPerWeek-1:0] day_bits(input logic [DaysW-1:0] mask,
                                                      input logic [WdayW-1:0] wday);
    logic [WdayW-1:0] wd;
    logic [3:0]       d;
    logic [DaysPerWeek-1:0] r;
    wd = (wday == 3'd7) ? 3'd0 : wday;
    r  = '0;
    for (int b = 0; b < DaysPerWeek; b++) begin
      d = {1'b0, wd} + 4'(DaysPerWeek - b);
      if (d >= 4'(DaysPerWeek)) begin
        d = d - 4'(DaysPerWeek);
      end
      r[b] = mask[d[2:0]];
    end
    return r;
  endfunction

endpackage

// ===== design/weekly_setpoint_schedule_unit.sv =====
// Top level of the weekly setpoint schedule unit: microcoded sequencer and datapath.
// Depends on wss_pkg and the wss_ram entry table.
//
// Usage: input beats arrive on the s_axis channel. tuser selects the kind of beat:
// an entry write loads one table slot and clears the active index; a query carries
// the weekday, hour, minute and a time-valid flag and produces exactly one output
// beat on m_axis with the changed flag (tuser), the new setpoint and the active index.
// Entry writes produce no output beat. A query scans the used part of the table one
// entry per cycle through the table's single read port, then reads the best entry
// back and registers the result; a query with the schedule disabled, the table empty
// or the time invalid skips the scan. Queries are handled one at a time, so the next
// beat is accepted in the cycle after the result is registered. The output register
// holds a finished beat while the receiver stalls; the next input beat is taken
// meanwhile, and a following query waits in its last step until the register is free.
// Reset clears the sequencer, the output valid, the configuration and the active
// index to none; table contents are undefined until written. Configuration is
// written through cfg_we_i, cfg_addr_i and cfg_wdata_i; the user must write it only
// while idle, as the block does not enforce this.
module weekly_setpoint_schedule_unit #(
  parameter int MaxEntries = wss_pkg::MaxEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_slot, day_mask, start_minute, entry_temp, weekday, hour, minute, time_valid
  input  logic [wss_pkg::SDataW-1:0]    s_axis_tdata,
  // operation
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // setpoint, active_index
  output logic [wss_pkg::MDataW-1:0]    m_axis_tdata,
  // setpoint_changed
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [wss_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [wss_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  import wss_pkg::*;

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int CmpW = ((CntW > CfgCntW) ? CntW : CfgCntW) + 1;

  logic [SlotW-1:0]   in_slot;
  logic [DaysW-1:0]   in_days;
  logic [MinuteW-1:0] in_start;
  logic [TempW-1:0]   in_temp;
  logic [WdayW-1:0]   in_wday;
  logic [HourW-1:0]   in_hour;
  logic [MinW-1:0]    in_min;
  logic               in_tvalid;

  assign in_slot   = s_axis_tdata[3:0];
  assign in_days   = s_axis_tdata[10:4];
  assign in_start  = s_axis_tdata[21:11];
  assign in_temp   = s_axis_tdata[33:22];
  assign in_wday   = s_axis_tdata[36:34];
  assign in_hour   = s_axis_tdata[41:37];
  assign in_min    = s_axis_tdata[47:42];
  assign in_tvalid = s_axis_tdata[48];

  logic [StepW-1:0]   pc_q, pc_d;
  ctrl_t              cw;
  logic               en_q, en_d;
  logic [CfgCntW-1:0] cnt_q, cnt_d;
  logic [WdayW-1:0]   wd_q, wd_d;
  logic [MinuteW-1:0] thresh_q, thresh_d;
  logic               tv_q, tv_d;
  logic [CntW-1:0]    ptr_q, ptr_d;
  logic               rd_valid_q, rd_valid_d;
  logic [IdxW-1:0]    rd_idx_q, rd_idx_d;
  logic               best_found_q, best_found_d;
  logic [2:0]         best_b_q, best_b_d;
  logic [MinuteW-1:0] best_min_q, best_min_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic               nvalid_q, nvalid_d;
  logic [IdxW-1:0]    nidx_q, nidx_d;
  logic               last_valid_q, last_valid_d;
  logic [IdxW-1:0]    last_idx_q, last_idx_d;
  logic               m_valid_q, m_valid_d;
  logic [MDataW-1:0]  m_data_q, m_data_d;
  logic               m_user_q, m_user_d;

  logic               in_acc, out_free, skip, last_ptr, cond_ok;
  logic [CmpW-1:0]    used;
  logic               ram_we, ram_re;
  logic [IdxW-1:0]    ram_raddr;
  logic [EntryW-1:0]  ram_rdata;
  logic [DaysW-1:0]   rd_days;
  logic [MinuteW-1:0] rd_min;
  logic [TempW-1:0]   rd_temp;
  logic [DaysPerWeek-1:0] rot, cand;
  logic [2:0]         cand_b;
  logic               better, changed;

  assign cw            = ucode_rom(pc_q);
  assign s_axis_tready = (pc_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign used          = (CmpW'(cnt_q) > CmpW'(MaxEntries)) ? CmpW'(MaxEntries)
                                                            : CmpW'(cnt_q);
  assign skip          = !en_q || (cnt_q == '0) || !tv_q;
  assign last_ptr      = (CmpW'(ptr_q) + CmpW'(1)) >= used;

  assign ram_we    = in_acc && (s_axis_tuser == OpWrite)
                     && (CmpW'(in_slot) < CmpW'(MaxEntries));
  assign ram_re    = cw.rd_scan || cw.rd_best;
  assign ram_raddr = cw.rd_best ? best_idx_q : ptr_q[IdxW-1:0];

  wss_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(in_slot)),
    .wdata_i ({in_temp, in_start, in_days}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_days = ram_rdata[DaysW-1:0];
  assign rd_min  = ram_rdata[DaysW+MinuteW-1:DaysW];
  assign rd_temp = ram_rdata[EntryW-1:DaysW+MinuteW];

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    cond_ok = 1'b0;
      C_ALWAYS:   cond_ok = 1'b1;
      C_QUERY:    cond_ok = in_acc && (s_axis_tuser == OpQuery);
      C_SKIP:     cond_ok = skip;
      C_LAST:     cond_ok = last_ptr;
      C_OUT_FREE: cond_ok = out_free;
      default:    cond_ok = 1'b0;
    endcase
    if (cond_ok) begin
      pc_d = cw.target;
    end else if (cw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + StepW'(1);
    end
  end

  // Each entry is ranked by how many days back it first applies, then by later start.
  always_comb begin
    rot     = day_bits(rd_days, wd_q);
    cand[0] = rot[0] && (rd_min <= thresh_q);
    for (int b = 1; b < DaysPerWeek; b++) begin
      cand[b] = rot[b] && (rd_min <= MinuteW'(MinPerDay));
    end
    cand_b = 3'd0;
    for (int b = DaysPerWeek - 1; b >= 0; b--) begin
      if (cand[b]) begin
        cand_b = 3'(b);
      end
    end
    better = rd_valid_q && (cand != '0)
             && (!best_found_q || (cand_b < best_b_q)
                 || ((cand_b == best_b_q) && (rd_min > best_min_q)));
  end

  assign changed = nvalid_q && (!last_valid_q || (nidx_q != last_idx_q));

  always_comb begin
    en_d         = en_q;
    cnt_d        = cnt_q;
    wd_d         = wd_q;
    thresh_d     = thresh_q;
    tv_d         = tv_q;
    ptr_d        = ptr_q;
    rd_valid_d   = cw.rd_scan;
    rd_idx_d     = ptr_q[IdxW-1:0];
    best_found_d = best_found_q;
    best_b_d     = best_b_q;
    best_min_d   = best_min_q;
    best_idx_d   = best_idx_q;
    nvalid_d     = nvalid_q;
    nidx_d       = nidx_q;
    last_valid_d = last_valid_q;
    last_idx_d   = last_idx_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgEnabled: en_d  = cfg_wdata_i[0];
        CfgCount:   cnt_d = cfg_wdata_i[CfgCntW-1:0];
        default:    en_d  = en_q;
      endcase
    end

    if (in_acc) begin
      if (s_axis_tuser == OpWrite) begin
        last_valid_d = 1'b0;
      end else begin
        wd_d     = in_wday;
        thresh_d = MinuteW'(in_hour) * MinuteW'(MinPerHour) + MinuteW'(in_min);
        tv_d     = in_tvalid;
      end
    end

    if (cw.init) begin
      ptr_d        = '0;
      best_found_d = 1'b0;
      nvalid_d     = en_q && (cnt_q != '0) && last_valid_q;
      nidx_d       = last_idx_q;
    end

    if (cw.rd_scan) begin
      ptr_d = ptr_q + CntW'(1);
    end

    if (better) begin
      best_found_d = 1'b1;
      best_b_d     = cand_b;
      best_min_d   = rd_min;
      best_idx_d   = rd_idx_q;
    end

    if (cw.rd_best) begin
      nvalid_d = best_found_q;
      nidx_d   = best_idx_q;
    end

    if (cw.emit && out_free) begin
      m_valid_d    = 1'b1;
      m_user_d     = changed;
      m_data_d     = {7'd0, (nvalid_q ? IndexW'(nidx_q) : {IndexW{1'b1}}),
                      (changed ? rd_temp : TempW'(0))};
      last_valid_d = nvalid_q;
      last_idx_d   = nidx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= S_IDLE;
      en_q         <= 1'b0;
      cnt_q        <= '0;
      rd_valid_q   <= 1'b0;
      best_found_q <= 1'b0;
      nvalid_q     <= 1'b0;
      last_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      en_q         <= en_d;
      cnt_q        <= cnt_d;
      rd_valid_q   <= rd_valid_d;
      best_found_q <= best_found_d;
      nvalid_q     <= nvalid_d;
      last_valid_q <= last_valid_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wd_q       <= wd_d;
    thresh_q   <= thresh_d;
    tv_q       <= tv_d;
    ptr_q      <= ptr_d;
    rd_idx_q   <= rd_idx_d;
    best_b_q   <= best_b_d;
    best_min_q <= best_min_d;
    best_idx_q <= best_idx_d;
    nidx_q     <= nidx_d;
    last_idx_q <= last_idx_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== design/wss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module wss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_weekly_setpoint_schedule_unit.sv =====
// Self-checking testbench for weekly_setpoint_schedule_unit: loads schedule entries,
// queries the setpoint in force under random stalls, and checks each result beat.
// Depends on wss_pkg and the unit's RTL; needs no files or arguments.
module tb_weekly_setpoint_schedule_unit;
  import wss_pkg::*;

  localparam int NumEntries    = MaxEntriesDef;
  localparam int SettleCycles  = 40;
  localparam int HoldOffCycles = 400;

  typedef struct packed {
    logic [SDataW-50:0]      pad;
    logic                    time_valid;
    logic [MinW-1:0]         minute;
    logic [HourW-1:0]        hour;
    logic [WdayW-1:0]        weekday;
    logic signed [TempW-1:0] entry_temp;
    logic [MinuteW-1:0]      start_minute;
    logic [DaysW-1:0]        day_mask;
    logic [SlotW-1:0]        entry_slot;
  } sched_beat_t;

  typedef struct packed {
    logic [MDataW-18:0] pad;
    logic [IndexW-1:0]  active_index;
    logic [TempW-1:0]   setpoint;
  } sched_out_t;

  typedef struct packed {
    logic               changed;
    logic [TempW-1:0]   setpoint;
    logic [IndexW-1:0]  active_index;
  } setpoint_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SDataW-1:0]   s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [MDataW-1:0]   m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic [DaysW-1:0]    sched_days  [NumEntries];
  logic [MinuteW-1:0]  sched_start [NumEntries];
  logic [TempW-1:0]    sched_temp  [NumEntries];
  int                  active_now = -1;
  logic                sched_enabled = 1'b0;
  logic [CfgCntW-1:0]  sched_count = '0;
  setpoint_report_t    pending_reports[$];

  int     errors = 0;
  int     n_writes = 0;
  int     n_queries = 0;
  int     n_checked = 0;
  int     n_changed = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cyc = 0;
  longint recv_hold_until = 0;

  weekly_setpoint_schedule_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  always @(negedge clk_i) begin
    if (cyc < recv_hold_until) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d", cyc, what, got, want);
    end
  endtask

  function automatic int find_entry_in_force(input int wday, input int thresh_today);
    int used;
    int day;
    int lim;
    int best;
    int best_min;
    used = (sched_count > NumEntries) ? NumEntries : int'(sched_count);
    for (int back = 0; back < DaysPerWeek; back++) begin
      day = (wday + DaysPerWeek - back) % DaysPerWeek;
      lim = (back == 0) ? thresh_today : MinPerDay;
      best = -1;
      best_min = -1;
      for (int i = 0; i < used; i++) begin
        if (sched_days[i][day] && int'(sched_start[i]) <= lim &&
            int'(sched_start[i]) > best_min) begin
          best_min = int'(sched_start[i]);
          best = i;
        end
      end
      if (best >= 0) begin
        return best;
      end
    end
    return -1;
  endfunction

  task automatic apply_beat(input logic op, input sched_beat_t b);
    int idx;
    setpoint_report_t r;
    if (op == OpWrite) begin
      sched_days[b.entry_slot]  = b.day_mask;
      sched_start[b.entry_slot] = b.start_minute;
      sched_temp[b.entry_slot]  = b.entry_temp;
      active_now = -1;
      n_writes++;
    end else begin
      if (!sched_enabled || sched_count == 0) begin
        idx = -1;
      end else if (!b.time_valid) begin
        idx = active_now;
      end else begin
        idx = find_entry_in_force(int'(b.weekday), int'(b.hour) * MinPerHour + int'(b.minute));
      end
      r = '0;
      if (idx != active_now) begin
        active_now = idx;
        if (idx >= 0) begin
          r.changed  = 1'b1;
          r.setpoint = sched_temp[idx];
        end
      end
      r.active_index = IndexW'(active_now);
      pending_reports = {pending_reports, r};
      n_queries++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    sched_out_t       got;
    setpoint_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected", int'($signed(got.active_index)),
                        -2);
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        if (want.changed) begin
          n_changed++;
        end
        if (m_axis_tuser !== want.changed) begin
          report_mismatch("setpoint_changed", int'(m_axis_tuser), int'(want.changed));
        end
        if (got.setpoint !== want.setpoint) begin
          report_mismatch("setpoint", int'($signed(got.setpoint)),
                          int'($signed(want.setpoint)));
        end
        if (got.active_index !== want.active_index) begin
          report_mismatch("active_index", int'($signed(got.active_index)),
                          int'($signed(want.active_index)));
        end
      end
    end
  end

  task automatic send_beat(input logic op, input sched_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    apply_beat(op, b);
  endtask

  task automatic wait_until_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] addr, input int value);
    wait_until_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= CfgDataW'(value);
    if (addr == CfgEnabled) begin
      sched_enabled = value[0];
    end else begin
      sched_count = CfgCntW'(value);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_entry(input int slot, input int mask, input int start, input int temp);
    sched_beat_t b;
    b = '0;
    b.entry_slot   = SlotW'(slot);
    b.day_mask     = DaysW'(mask);
    b.start_minute = MinuteW'(start);
    b.entry_temp   = TempW'(temp);
    send_beat(OpWrite, b);
  endtask

  task automatic query_at(input int wday, input int hr, input int mn, input logic valid);
    sched_beat_t b;
    b = '0;
    b.weekday    = WdayW'(wday);
    b.hour       = HourW'(hr);
    b.minute     = MinW'(mn);
    b.time_valid = valid;
    send_beat(OpQuery, b);
  endtask

  // Entry times cluster on a few values so that ties and same-day ordering are common.
  function automatic sched_beat_t shaped_beat(input logic op);
    sched_beat_t b;
    int pick;
    b = SDataW'({$urandom, $urandom});
    b.pad = '0;
    pick = $urandom_range(99);
    if (pick < 10) begin
      b.day_mask = '0;
    end else if (pick < 20) begin
      b.day_mask = '1;
    end else if (pick < 50) begin
      b.day_mask = DaysW'(1 << $urandom_range(DaysPerWeek - 1));
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      b.start_minute = MinuteW'($urandom_range(2047, MinPerDay));
    end else if (pick < 35) begin
      case ($urandom_range(3))
        0: b.start_minute = '0;
        1: b.start_minute = MinuteW'(480);
        2: b.start_minute = MinuteW'(720);
        default: b.start_minute = MinuteW'(MinPerDay - 1);
      endcase
    end else begin
      b.start_minute = MinuteW'($urandom_range(MinPerDay - 1));
    end
    if (op == OpQuery) begin
      b.weekday    = ($urandom_range(9) == 0) ? WdayW'(7) : WdayW'($urandom_range(6));
      b.hour       = ($urandom_range(9) == 0) ? HourW'($urandom_range(31, 24))
                                              : HourW'($urandom_range(23));
      b.minute     = ($urandom_range(9) == 0) ? MinW'($urandom_range(63, 60))
                                              : MinW'($urandom_range(59));
      b.time_valid = ($urandom_range(9) != 0);
    end
    return b;
  endfunction

  task automatic run_random_items(input int count, input int write_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < write_pct) begin
        send_beat(OpWrite, shaped_beat(OpWrite));
      end else begin
        send_beat(OpQuery, shaped_beat(OpQuery));
      end
    end
  endtask

  task automatic test_reset_state();
    query_at(0, 0, 0, 1'b1);
  endtask

  task automatic test_table_extremes();
    load_entry(0, 'h7F, 0, -2048);
    load_entry(1, 'h01, 480, 2047);
    load_entry(2, 'h02, 480, 336);
    load_entry(3, 'h40, MinPerDay - 1, -1);
    load_entry(4, 'h01, 480, 100);
    load_entry(5, 'h7F, MinPerDay, 555);
    load_entry(6, 'h00, 2047, 7);
    for (int s = 7; s < NumEntries; s++) begin
      load_entry(s, 'h00, s * 90, s * 16 - 200);
    end
    write_register(CfgEnabled, 1);
    write_register(CfgCount, NumEntries);
    query_at(0, 0, 0, 1'b1);
    query_at(0, 0, 0, 1'b1);
    query_at(0, 8, 0, 1'b1);
    query_at(1, 7, 59, 1'b1);
    query_at(7, 31, 63, 1'b1);
    query_at(3, 12, 0, 1'b0);
    query_at(6, 23, 59, 1'b1);
    load_entry(3, 'h08, 60, 1234);
    query_at(3, 1, 0, 1'b0);
    query_at(3, 1, 0, 1'b1);
    write_register(CfgEnabled, 0);
    query_at(2, 10, 0, 1'b1);
  endtask

  task automatic test_schedule_random(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_register(CfgEnabled, 1);
    write_register(CfgCount, NumEntries);
    run_random_items(100, 20);
    write_register(CfgCount, $urandom_range(NumEntries - 1, 1));
    run_random_items(80, 20);
    write_register(CfgCount, 31);
    run_random_items(50, 20);
    write_register(CfgEnabled, 0);
    run_random_items(20, 20);
    write_register(CfgEnabled, 1);
    write_register(CfgCount, 0);
    run_random_items(10, 20);
    write_register(CfgCount, 1);
    run_random_items(20, 20);
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    write_register(CfgCount, NumEntries);
    recv_hold_until = cyc + HoldOffCycles;
    run_random_items(40, 10);
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    run_random_items(20, 20);
    wait_until_idle();
    run_random_items(20, 20);
  endtask

  initial begin
    int guard;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_table_extremes();
    test_schedule_random(33, 85);
    test_schedule_random(85, 33);
    test_schedule_random(0, 0);
    test_output_stall();
    test_sender_pause();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_reports.size());
    end
    $display("Covered %0d entry writes and %0d queries; %0d result beats checked.",
             n_writes, n_queries, n_checked);
    $display("%0d setpoint changes seen, across enable, count, stall and pause settings.",
             n_changed);
    if (errors == 0) begin
      $display("tb_weekly_setpoint_schedule_unit OK");
    end else begin
      $display("tb_weekly_setpoint_schedule_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout after %0d cycles.", cyc);
    $display("tb_weekly_setpoint_schedule_unit NOT OK");
    $finish;
  end

endmodule
